// File: rtl/core/scfd_pkg.sv
package scfd_pkg;

	localparam int MAX_FRAME_DEF = 64;
	localparam int HEAD_DEPTH    = 5;

	// Frame bytes
	localparam logic [7:0] CH_TERM = 8'd35;   // '#'
	localparam logic [7:0] CH_AXIS = 8'd99;   // 'c'
	localparam logic [7:0] CH_GAIN = 8'd115;  // 's'
	localparam logic [7:0] CH_ZERO = 8'd122;  // 'z'
	localparam logic [7:0] CH_STOP = 8'd83;   // 'S'
	localparam logic [7:0] CH_P    = 8'd80;   // 'P'
	localparam logic [7:0] CH_I    = 8'd73;   // 'I'
	localparam logic [7:0] CH_D    = 8'd68;   // 'D'
	localparam logic [7:0] CH_W    = 8'd87;   // 'W'

	// Status codes
	localparam logic [2:0] ST_APPLIED   = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_BAD_SUM   = 3'd2;
	localparam logic [2:0] ST_BAD_LEN   = 3'd3;
	localparam logic [2:0] ST_BAD_AXIS  = 3'd4;
	localparam logic [2:0] ST_IGNORED   = 3'd5;
	localparam logic [2:0] ST_OVERRUN   = 3'd6;

	// Action codes
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_SET_AXIS  = 3'd1;
	localparam logic [2:0] ACT_SET_GAIN  = 3'd2;
	localparam logic [2:0] ACT_ZERO_INT  = 3'd3;
	localparam logic [2:0] ACT_SET_STOP  = 3'd4;

	// Gain select codes
	localparam logic [1:0] GAIN_P = 2'd0;
	localparam logic [1:0] GAIN_I = 2'd1;
	localparam logic [1:0] GAIN_D = 2'd2;
	localparam logic [1:0] GAIN_W = 2'd3;

	// Frame summary seen at the terminator
	typedef struct packed {
		logic                           over;
		logic                           too_short;
		logic                           sum_ok;
		logic                           len_is5;
		logic [HEAD_DEPTH-1:0][7:0]     head;
	} frm_sum_t;

	// One decoded result word
	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         action;
		logic [1:0]         target_index;
		logic [1:0]         gain_select;
		logic signed [15:0] value;
		logic               stop_flag;
	} res_t;

endpackage

// File: rtl/core/scfd_frame.sv
module scfd_frame #(
	parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,      // byte in stage 1 is consumed
	input  logic [7:0]        byte_s1,
	output scfd_pkg::frm_sum_t sum_o
);
	import scfd_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

	logic [CW-1:0]              count_q;
	logic [7:0]                 rsum_q;
	logic [7:0]                 last_q;
	logic [HEAD_DEPTH-1:0][7:0] head_q;
	logic                       over_q;
	logic                       is_term;
	logic                       full;

	assign is_term = (byte_s1 == CH_TERM);
	assign full    = (count_q == CNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsum_q  <= '0;
			last_q  <= '0;
			head_q  <= '0;
			over_q  <= 1'b0;
		end else if (fire) begin
			if (is_term) begin
				count_q <= '0;
				rsum_q  <= '0;
				over_q  <= 1'b0;
			end else if (full) begin
				over_q <= 1'b1;
			end else begin
				for (int k = 0; k < HEAD_DEPTH; k++) begin
					if (count_q == CW'(k))
						head_q[k] <= byte_s1;
				end
				rsum_q  <= rsum_q + byte_s1;
				last_q  <= byte_s1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		sum_o.over      = over_q;
		sum_o.too_short = (count_q < CW'(2));
		sum_o.sum_ok    = ((rsum_q - last_q) == last_q);
		sum_o.len_is5   = (count_q == CW'(5));
		sum_o.head      = head_q;
	end

endmodule

// File: rtl/core/scfd_decode.sv
module scfd_decode (
	input  scfd_pkg::frm_sum_t sum_i,
	output scfd_pkg::res_t     res_o
);
	import scfd_pkg::*;

	logic [7:0]  cmd;
	logic [7:0]  arg0;
	logic [15:0] axis_val;
	logic [15:0] gain_val;

	assign cmd      = sum_i.head[0];
	assign arg0     = sum_i.head[1];
	assign axis_val = {sum_i.head[2], sum_i.head[3]};
	assign gain_val = {sum_i.head[3], sum_i.head[4]};

	always_comb begin
		res_o = '0;
		res_o.status = ST_IGNORED;
		if (sum_i.over) begin
			res_o.status = ST_OVERRUN;
		end else if (sum_i.too_short) begin
			res_o.status = ST_TOO_SHORT;
		end else if (!sum_i.sum_ok) begin
			res_o.status = ST_BAD_SUM;
		end else begin
			unique case (cmd)
				CH_AXIS: begin
					if (!sum_i.len_is5)
						res_o.status = ST_BAD_LEN;
					else if (arg0 > 8'd3)
						res_o.status = ST_BAD_AXIS;
					else begin
						res_o.status       = ST_APPLIED;
						res_o.action       = ACT_SET_AXIS;
						res_o.target_index = arg0[1:0];
						res_o.value        = axis_val;
					end
				end
				CH_GAIN: begin
					if (arg0 > 8'd1)
						res_o.status = ST_BAD_AXIS;
					else if (!gain_val[15]) begin
						// unknown gain letter stays ignored
						unique case (sum_i.head[2])
							CH_P, CH_I, CH_D, CH_W: begin
								res_o.status       = ST_APPLIED;
								res_o.action       = ACT_SET_GAIN;
								res_o.target_index = arg0[1:0];
								res_o.value        = gain_val;
							end
							default: res_o.status = ST_IGNORED;
						endcase
						unique case (sum_i.head[2])
							CH_I:    res_o.gain_select = GAIN_I;
							CH_D:    res_o.gain_select = GAIN_D;
							CH_W:    res_o.gain_select = GAIN_W;
							default: res_o.gain_select = GAIN_P;
						endcase
					end
				end
				CH_ZERO: begin
					res_o.status = ST_APPLIED;
					res_o.action = ACT_ZERO_INT;
				end
				CH_STOP: begin
					if (arg0 == 8'd1 || arg0 == 8'd0) begin
						res_o.status    = ST_APPLIED;
						res_o.action    = ACT_SET_STOP;
						res_o.stop_flag = arg0[0];
					end
				end
				default: res_o.status = ST_IGNORED;
			endcase
		end
	end

endmodule

// File: rtl/core/serial_command_frame_decoder.sv
// Serial command frame decoder.
// A '#' word gives its result word after acceptance by way of the input
// register, then frame state and decode into the result register.
// Throughput: one byte word per cycle while in_stall is low; set by the single frame-state update.
// Reset (arst_n low, asynchronous): frame length, sum, last byte, head bytes,
// overrun mark and both valid flags clear.
module serial_command_frame_decoder #(
	parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         byte_in,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [2:0]         action,
	output logic [1:0]         target_index,
	output logic [1:0]         gain_select,
	output logic signed [15:0] value,
	output logic               stop_flag
);
	import scfd_pkg::*;

	// Stage 1: input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       term_s1;
	logic       blocked;   // terminator in stage 1 has nowhere to go
	logic       fire;      // stage 1 word consumed by the frame logic
	logic       in_acc;

	// Result register
	logic       res_vld_q;
	res_t       res_q;
	res_t       res_d;
	frm_sum_t   fsum;

	assign term_s1 = (byte_s1 == CH_TERM);
	// Only a terminator needs the result register; data bytes always drain.
	assign blocked  = vld_s1 && term_s1 && res_vld_q && out_stall;
	assign fire     = vld_s1 && !blocked;
	assign in_stall = blocked;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!blocked) begin
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			byte_s1 <= byte_in;
	end

	// Frame state: length, running sum, last byte, head bytes, overrun mark
	scfd_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.byte_s1(byte_s1),
		.sum_o  (fsum)
	);

	// Length/checksum checks and command decode
	scfd_decode u_decode (
		.sum_i(fsum),
		.res_o(res_d)
	);

	// Result register: loads on a terminator, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (fire && term_s1) begin
			res_vld_q <= 1'b1;
		end else if (!out_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && term_s1)
			res_q <= res_d;
	end

	assign out_valid    = res_vld_q;
	assign status       = res_q.status;
	assign action       = res_q.action;
	assign target_index = res_q.target_index;
	assign gain_select  = res_q.gain_select;
	assign value        = res_q.value;
	assign stop_flag    = res_q.stop_flag;

endmodule
